// ----- rtl/core/efd_pkg.sv -----
`default_nettype none

package efd_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CNT_W         = 12;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned MAX_FRAME_DEF = 2048;

  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hAA;
  localparam logic [BYTE_W-1:0] ESC_OFFSET = 8'h10;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'hA0;
  localparam logic [BYTE_W-1:0] STOP_CODE_RST  = 8'hA5;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE  = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_FRAME = 2'd1,
    PH_ESC   = 2'd2
  } efd_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] stop_code;
  } efd_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              first_of_frame;
    logic              last_of_frame;
    logic              overflow;
  } efd_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/efd_cfg_regs.sv -----
`default_nettype none

module efd_cfg_regs import efd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  output efd_cfg_t                  cfg
);

  efd_cfg_t cfg_r;
  efd_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_CODE: cfg_nxt.start_code = cfg_data;
        REG_STOP_CODE:  cfg_nxt.stop_code  = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code <= START_CODE_RST;
      cfg_r.stop_code  <= STOP_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/efd_decode.sv -----
`default_nettype none

module efd_decode import efd_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire efd_cfg_t          cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              slot_free,
  output logic                   res_vld,
  output efd_result_t            res
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FRAME);

  logic              in_vld_r;
  logic              in_vld_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  efd_phase_t        phase_r;
  efd_phase_t        phase_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;

  logic              accept;
  logic              consume;
  logic              emit;
  logic              is_first;
  logic              is_stop;
  logic              is_ovf;
  logic [BYTE_W-1:0] data;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W-1:0]  cnt_inc;

  // input register drains whenever the result register has room
  assign consume  = in_vld_r && slot_free;
  assign in_stall = in_vld_r && !slot_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
  end

  // classify the held byte
  always_comb begin
    emit     = 1'b0;
    is_first = 1'b0;
    is_stop  = 1'b0;
    data     = in_byte_r;
    cnt_base = cnt_r;
    unique case (phase_r)
      PH_FRAME: begin
        emit    = (in_byte_r != ESC_BYTE);
        is_stop = (in_byte_r == cfg.stop_code);
      end
      PH_ESC: begin
        emit = 1'b1;
        data = in_byte_r - ESC_OFFSET;
      end
      default: begin
        // hunting; the unused phase code hunts too
        emit     = (in_byte_r == cfg.start_code);
        is_first = 1'b1;
        cnt_base = '0;
      end
    endcase
  end

  assign cnt_inc = cnt_base + CNT_W'(1);
  assign is_ovf  = emit && !is_stop && (cnt_inc >= MaxCnt);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (consume) begin
      unique case (phase_r)
        PH_FRAME: phase_nxt = (in_byte_r == ESC_BYTE) ? PH_ESC : PH_FRAME;
        PH_ESC:   phase_nxt = PH_FRAME;
        default:  phase_nxt = emit ? PH_FRAME : PH_HUNT;
      endcase
      if (emit) begin
        if (is_stop || is_ovf) begin
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  // outputs
  always_comb begin
    res_vld            = consume && emit;
    res.frame_byte     = data;
    res.first_of_frame = is_first;
    res.last_of_frame  = is_stop || is_ovf;
    res.overflow       = is_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_HUNT;
      cnt_r    <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_ovf_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.overflow |-> res.last_of_frame)
    else $error("overflow without last");

  a_first_is_start: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.first_of_frame |->
      !res.last_of_frame && (res.frame_byte == cfg.start_code))
    else $error("bad first byte");

  a_hunt_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT |-> cnt_r == '0)
    else $error("count not cleared while hunting");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < MaxCnt)
    else $error("frame count beyond max");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/efd_out_reg.sv -----
`default_nettype none

module efd_out_reg import efd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_vld,
  input  wire efd_result_t res,
  output logic             slot_free,
  output logic             out_valid,
  input  wire logic        out_stall,
  output efd_result_t      out_res
);

  logic        vld_r;
  logic        vld_nxt;
  efd_result_t res_r;

  assign slot_free = !vld_r || !out_stall;
  assign vld_nxt   = res_vld || (vld_r && out_stall);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/escaped_frame_deframer.sv -----
// Channel   Handshake          Payload
// in_       in_valid/in_stall  in_rx_byte[7:0]
// out_      out_valid/out_stall out_frame_byte[7:0], out_first_of_frame,
//                              out_last_of_frame, out_overflow
// cfg_      cfg_valid/cfg_ready cfg_index (0 start_code, 1 stop_code), cfg_data[7:0]
//
// One byte per cycle sustained while out_stall is low. A byte sits in the input
// register, is decoded, and an emitted byte lands in the result register (out_valid).
// Reset (rst_n low, synchronous) returns to hunting with the frame count cleared
// and the codes at 0xA0 / 0xA5. out_stall holds the result register; in_stall
// rises only while both the input and the result register are full.
`default_nettype none

module escaped_frame_deframer import efd_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         out_frame_byte,
  output logic                      out_first_of_frame,
  output logic                      out_last_of_frame,
  output logic                      out_overflow,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  efd_cfg_t    cfg;
  efd_result_t res;
  efd_result_t out_res;
  logic        res_vld;
  logic        slot_free;

  efd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  efd_decode #(
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .slot_free  (slot_free),
    .res_vld    (res_vld),
    .res        (res)
  );

  efd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_frame_byte     = out_res.frame_byte;
  assign out_first_of_frame = out_res.first_of_frame;
  assign out_last_of_frame  = out_res.last_of_frame;
  assign out_overflow       = out_res.overflow;

endmodule

`default_nettype wire
